// ----- rtl/bsp_pkg.sv -----
// Shared types, constants and the sine/cosine table of the sprite projector.
package bsp_pkg;

  localparam int ANGLE_STEPS = 1024;
  localparam int ANGLE_W = 10;
  localparam int SC_ROM_DEPTH = 2 ** ANGLE_W;

  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint TWO_PI_Q30 = 64'sd6746518852;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam logic signed [31:0] NEAR_Q22 = 32'sd419430;

  localparam int DIV_STEPS = 35;
  localparam int NUM_W = 53;
  localparam int REM_W = 44;
  localparam int CX_W = 30;
  localparam int WABS_W = 41;
  localparam int FRAC_SHIFT = 12;
  localparam int SZ_STEPS = 15;
  localparam int SZ_SHIFT = 22;
  localparam int SZ_NUM_W = 11 + SZ_SHIFT;
  localparam int SZ_REM_W = CX_W;
  localparam int Q_W = DIV_STEPS + 1;
  localparam int N_W = Q_W + 1;
  localparam int CENTER_MAX = 32767;
  localparam int CENTER_MIN = -32768;
  localparam int FRONT_STAGES = 5;
  localparam int FINISH_STAGES = 4;
  localparam int LATENCY = FRONT_STAGES + DIV_STEPS + FINISH_STAGES;

  localparam logic [10:0] WIDTH_RESET = 11'd640;
  localparam logic [10:0] HEIGHT_RESET = 11'd480;
  localparam logic [10:0] CENTER_ROW_RESET = 11'd240;
  localparam logic [13:0] PLANE_RESET = 14'd2365;

  typedef enum logic [1:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_CENTER_ROW,
    REG_PLANE
  } cfg_idx_t;

  typedef struct packed {
    logic [10:0] width;
    logic [10:0] height;
    logic [10:0] center_row;
    logic [13:0] plane;
  } cfg_t;

  typedef struct packed {
    logic near;
    logic kind;
    logic msign;
    logic [14:0] depth;
  } side_t;

  typedef logic [31:0] sc_rom_t [SC_ROM_DEPTH];

  // The argument is never negative and stays below two full turns.
  function automatic logic signed [15:0] sin_q14(input longint t_in);
    longint t;
    logic neg;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint sum;
    t = t_in;
    if (t >= TWO_PI_Q30) t = t - TWO_PI_Q30;
    neg = 1'b0;
    if (t < 0) t = t + TWO_PI_Q30;
    if (t >= PI_Q30) begin
      neg = 1'b1;
      t = t - PI_Q30;
    end
    if (t > HALF_PI_Q30) t = PI_Q30 - t;
    x = longint'(t);
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int k = 1; k <= 6; k++) begin
      term = (term * x2) >> 30;
      case (k)
        1: term = term / 64'd6;
        2: term = term / 64'd20;
        3: term = term / 64'd42;
        4: term = term / 64'd72;
        5: term = term / 64'd110;
        default: term = term / 64'd156;
      endcase
      if (k % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    sum = (sum + 32768) >>> 16;
    if (sum > 16384) sum = 16384;
    return neg ? -16'(sum) : 16'(sum);
  endfunction

  function automatic sc_rom_t build_sc_rom();
    sc_rom_t rom;
    longint a;
    longint theta;
    for (int i = 0; i < SC_ROM_DEPTH; i++) begin
      a = longint'(i % ANGLE_STEPS);
      theta = (TWO_PI_Q30 * a) / ANGLE_STEPS;
      rom[i] = {sin_q14(theta), sin_q14(theta + HALF_PI_Q30)};
    end
    return rom;
  endfunction

  localparam sc_rom_t SC_ROM = build_sc_rom();

endpackage

// ----- rtl/bsp_front.sv -----
// Front stages: table lookup, camera rotation and divider operand preparation.
module bsp_front import bsp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                accept,
  input  logic [13:0]         sprite_x,
  input  logic [13:0]         sprite_y,
  input  logic [13:0]         viewer_x,
  input  logic [13:0]         viewer_y,
  input  logic [ANGLE_W-1:0]  view_angle,
  input  logic                sprite_kind,
  output logic                out_valid,
  output side_t               out_side,
  output logic [NUM_W-1:0]    out_num,
  output logic [REM_W-1:0]    out_den,
  output logic [CX_W-1:0]     out_cx
);

  logic v0, v1, v2, v3, v4;
  logic k0, k1, k2;
  logic signed [14:0] dx0, dy0;
  logic [31:0] sc0;
  logic signed [30:0] p_xc, p_ys, p_yc, p_xs;
  logic signed [31:0] cx2, cy2;
  side_t side3, side4;
  logic [REM_W-1:0] q3, q4;
  logic signed [42:0] wc3;
  logic [CX_W-1:0] cx3, cx4;
  logic [WABS_W-1:0] wabs4;
  logic [13:0] plane_eff;
  logic signed [15:0] sin0, cos0;

  assign sin0 = sc0[31:16];
  assign cos0 = sc0[15:0];
  assign plane_eff = (cfg.plane == 14'd0) ? 14'd1 : cfg.plane;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v0 <= accept;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    dx0 <= $signed({1'b0, sprite_x}) - $signed({1'b0, viewer_x});
    dy0 <= $signed({1'b0, sprite_y}) - $signed({1'b0, viewer_y});
    sc0 <= SC_ROM[view_angle];
    k0 <= sprite_kind;

    p_xc <= 31'(dx0) * 31'(cos0);
    p_ys <= 31'(dy0) * 31'(sin0);
    p_yc <= 31'(dy0) * 31'(cos0);
    p_xs <= 31'(dx0) * 31'(sin0);
    k1 <= k0;

    cx2 <= 32'(p_xc) + 32'(p_ys);
    cy2 <= 32'(p_yc) - 32'(p_xs);
    k2 <= k1;

    side3.near <= (cx2 <= NEAR_Q22) || (cfg.width == 11'd0);
    side3.kind <= k2;
    side3.msign <= 1'b0;
    side3.depth <= (cx2[29:14] > 16'd32767) ? 15'h7FFF : cx2[28:14];
    q3 <= REM_W'(cx2[CX_W-1:0]) * REM_W'(plane_eff);
    wc3 <= 43'(cy2) * 43'($signed({1'b0, cfg.width}));
    cx3 <= cx2[CX_W-1:0];

    side4 <= {side3.near, side3.kind, wc3[42], side3.depth};
    wabs4 <= wc3[42] ? WABS_W'(-wc3) : WABS_W'(wc3);
    q4 <= q3;
    cx4 <= cx3;
  end

  assign out_valid = v4;
  assign out_side = side4;
  assign out_num = {wabs4, {FRAC_SHIFT{1'b0}}};
  assign out_den = q4;
  assign out_cx = cx4;

endmodule

// ----- rtl/bsp_div.sv -----
// Pipelined restoring divider with a column lane and a sprite size lane.
module bsp_div import bsp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [10:0]          height,
  input  logic                 in_valid,
  input  side_t                in_side,
  input  logic [NUM_W-1:0]     in_num,
  input  logic [REM_W-1:0]     in_den,
  input  logic [CX_W-1:0]      in_cx,
  output logic                 out_valid,
  output side_t                out_side,
  output logic [DIV_STEPS-1:0] out_quo,
  output logic                 out_rem_nz,
  output logic [SZ_STEPS-1:0]  out_size
);

  logic                 vld   [DIV_STEPS];
  side_t                side  [DIV_STEPS];
  logic [REM_W-1:0]     rem_a [DIV_STEPS];
  logic [DIV_STEPS-1:0] nq_a  [DIV_STEPS];
  logic [REM_W-1:0]     den   [DIV_STEPS];
  logic [SZ_REM_W-1:0]  rem_b [DIV_STEPS];
  logic [SZ_STEPS-1:0]  nq_b  [DIV_STEPS];
  logic [CX_W-1:0]      cxd   [DIV_STEPS];

  logic [REM_W-1:0]     rem_a_next [DIV_STEPS];
  logic [DIV_STEPS-1:0] nq_a_next  [DIV_STEPS];
  logic [SZ_REM_W-1:0]  rem_b_next [DIV_STEPS];
  logic [SZ_STEPS-1:0]  nq_b_next  [DIV_STEPS];

  logic [SZ_NUM_W-1:0] sz_num;

  assign sz_num = {height, {SZ_SHIFT{1'b0}}};

  always_comb begin
    logic [REM_W-1:0] cur_rem_a;
    logic [DIV_STEPS-1:0] cur_nq_a;
    logic [REM_W-1:0] cur_den;
    logic [SZ_REM_W-1:0] cur_rem_b;
    logic [SZ_STEPS-1:0] cur_nq_b;
    logic [CX_W-1:0] cur_cx;
    logic [REM_W:0] trial_a;
    logic [SZ_REM_W:0] trial_b;
    for (int i = 0; i < DIV_STEPS; i++) begin
      if (i == 0) begin
        cur_rem_a = REM_W'(in_num[NUM_W-1:DIV_STEPS]);
        cur_nq_a = in_num[DIV_STEPS-1:0];
        cur_den = in_den;
        cur_rem_b = SZ_REM_W'(sz_num[SZ_NUM_W-1:SZ_STEPS]);
        cur_nq_b = sz_num[SZ_STEPS-1:0];
        cur_cx = in_cx;
      end else begin
        cur_rem_a = rem_a[i-1];
        cur_nq_a = nq_a[i-1];
        cur_den = den[i-1];
        cur_rem_b = rem_b[i-1];
        cur_nq_b = nq_b[i-1];
        cur_cx = cxd[i-1];
      end
      trial_a = {cur_rem_a, cur_nq_a[DIV_STEPS-1]};
      if (trial_a >= {1'b0, cur_den}) begin
        rem_a_next[i] = REM_W'(trial_a - {1'b0, cur_den});
        nq_a_next[i] = {cur_nq_a[DIV_STEPS-2:0], 1'b1};
      end else begin
        rem_a_next[i] = trial_a[REM_W-1:0];
        nq_a_next[i] = {cur_nq_a[DIV_STEPS-2:0], 1'b0};
      end
      trial_b = {cur_rem_b, cur_nq_b[SZ_STEPS-1]};
      if (i >= SZ_STEPS) begin
        rem_b_next[i] = cur_rem_b;
        nq_b_next[i] = cur_nq_b;
      end else if (trial_b >= {1'b0, cur_cx}) begin
        rem_b_next[i] = SZ_REM_W'(trial_b - {1'b0, cur_cx});
        nq_b_next[i] = {cur_nq_b[SZ_STEPS-2:0], 1'b1};
      end else begin
        rem_b_next[i] = trial_b[SZ_REM_W-1:0];
        nq_b_next[i] = {cur_nq_b[SZ_STEPS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DIV_STEPS; i++) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else begin
        vld[i] <= (i == 0) ? in_valid : vld[i-1];
      end
      side[i] <= (i == 0) ? in_side : side[i-1];
      den[i] <= (i == 0) ? in_den : den[i-1];
      cxd[i] <= (i == 0) ? in_cx : cxd[i-1];
      rem_a[i] <= rem_a_next[i];
      nq_a[i] <= nq_a_next[i];
      rem_b[i] <= rem_b_next[i];
      nq_b[i] <= nq_b_next[i];
    end
  end

  assign out_valid = vld[DIV_STEPS-1];
  assign out_side = side[DIV_STEPS-1];
  assign out_quo = nq_a[DIV_STEPS-1];
  assign out_rem_nz = (rem_a[DIV_STEPS-1] != '0);
  assign out_size = nq_b[DIV_STEPS-1];

endmodule

// ----- rtl/bsp_finish.sv -----
// Back stages: column rounding, visibility test, clipping and result registers.
module bsp_finish import bsp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 in_valid,
  input  side_t                in_side,
  input  logic [DIV_STEPS-1:0] in_quo,
  input  logic                 in_rem_nz,
  input  logic [SZ_STEPS-1:0]  in_size,
  output logic                 done,
  output logic                 visible,
  output logic [10:0]          col_left,
  output logic [10:0]          col_right,
  output logic [10:0]          row_top,
  output logic [10:0]          row_bottom,
  output logic signed [15:0]   center_col,
  output logic [15:0]          sprite_size,
  output logic [14:0]          depth,
  output logic                 kind_out
);

  function automatic logic signed [Q_W-1:0] half_trunc(input logic signed [N_W-1:0] n,
                                                       input logic rnz);
    logic signed [N_W-1:0] h;
    h = n >>> 1;
    if (n[N_W-1] && (rnz || n[0])) h = h + N_W'(1);
    return Q_W'(h);
  endfunction

  logic v0, v1, v2;
  side_t side0, side1, side2;
  logic rnz0, rnz1;
  logic [SZ_STEPS-1:0] sz0, sz1, sz2;
  logic signed [Q_W-1:0] qs0;
  logic signed [N_W-1:0] nl1, nr1, nc1;
  logic signed [17:0] tv1, tv2;
  logic [15:0] bt1, bt2;
  logic signed [Q_W-1:0] l2, r2, c2;
  logic [16:0] bsum;
  logic vis;

  assign bsum = 17'({cfg.center_row, 1'b0}) + 17'(sz0);
  assign vis = !side2.near && !r2[Q_W-1] && !(l2 >= $signed(Q_W'({1'b0, cfg.width})));

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      done <= 1'b0;
    end else begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    side0 <= in_side;
    rnz0 <= in_rem_nz;
    sz0 <= in_size;
    if (!in_side.msign) qs0 <= $signed({1'b0, in_quo});
    else if (in_rem_nz) qs0 <= ~$signed({1'b0, in_quo});
    else qs0 <= -$signed({1'b0, in_quo});

    side1 <= side0;
    rnz1 <= rnz0;
    sz1 <= sz0;
    nl1 <= N_W'(qs0) + N_W'(cfg.width) - N_W'(sz0);
    nr1 <= N_W'(qs0) + N_W'(cfg.width) + N_W'(sz0);
    nc1 <= N_W'(qs0) + N_W'(cfg.width);
    tv1 <= 18'({cfg.center_row, 1'b0}) - 18'(sz0);
    bt1 <= bsum[16:1];

    side2 <= side1;
    sz2 <= sz1;
    l2 <= half_trunc(nl1, rnz1);
    r2 <= half_trunc(nr1, rnz1);
    c2 <= half_trunc(nc1, rnz1);
    tv2 <= tv1;
    bt2 <= bt1;

    kind_out <= side2.kind;
    visible <= vis;
    if (!vis) begin
      col_left <= '0;
      col_right <= '0;
      row_top <= '0;
      row_bottom <= '0;
      center_col <= '0;
      sprite_size <= '0;
      depth <= '0;
    end else begin
      col_left <= l2[Q_W-1] ? 11'd0 : l2[10:0];
      col_right <= (r2 >= $signed(Q_W'({1'b0, cfg.width}))) ? 11'(cfg.width - 11'd1)
                                                           : r2[10:0];
      row_top <= tv2[17] ? 11'd0 : tv2[11:1];
      if (cfg.height == 11'd0) row_bottom <= 11'd0;
      else if (bt2 > 16'(cfg.height - 11'd1)) row_bottom <= 11'(cfg.height - 11'd1);
      else row_bottom <= bt2[10:0];
      if (c2 > Q_W'(CENTER_MAX)) center_col <= 16'(CENTER_MAX);
      else if (c2 < Q_W'(CENTER_MIN)) center_col <= 16'(CENTER_MIN);
      else center_col <= c2[15:0];
      sprite_size <= 16'(sz2);
      depth <= side2.depth;
    end
  end

endmodule

// ----- rtl/billboard_sprite_projector_core.sv -----
// Top level of the billboard sprite projector: configuration registers and pipeline.
// The projector takes one sprite request in every clock cycle and never holds
// requests off, so busy stays low. Each request comes out on the single cycle in
// which done is high, in request order; the downstream side must take it then.
// The pipeline is the 35-step column divider plus five front and four back
// stages. The screen registers may be written only when no request is in flight.
module billboard_sprite_projector_core import bsp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [13:0]         sprite_x,
  input  logic [13:0]         sprite_y,
  input  logic [13:0]         viewer_x,
  input  logic [13:0]         viewer_y,
  input  logic [ANGLE_W-1:0]  view_angle,
  input  logic                sprite_kind,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [13:0]         cfg_data,
  output logic                done,
  output logic                visible,
  output logic [10:0]         col_left,
  output logic [10:0]         col_right,
  output logic [10:0]         row_top,
  output logic [10:0]         row_bottom,
  output logic signed [15:0]  center_col,
  output logic [15:0]         sprite_size,
  output logic [14:0]         depth,
  output logic                kind_out
);

  cfg_t cfg;
  logic f_valid;
  side_t f_side;
  logic [NUM_W-1:0] f_num;
  logic [REM_W-1:0] f_den;
  logic [CX_W-1:0] f_cx;
  logic d_valid;
  side_t d_side;
  logic [DIV_STEPS-1:0] d_quo;
  logic d_rem_nz;
  logic [SZ_STEPS-1:0] d_size;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width <= WIDTH_RESET;
      cfg.height <= HEIGHT_RESET;
      cfg.center_row <= CENTER_ROW_RESET;
      cfg.plane <= PLANE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_WIDTH:      cfg.width <= cfg_data[10:0];
        REG_HEIGHT:     cfg.height <= cfg_data[10:0];
        REG_CENTER_ROW: cfg.center_row <= cfg_data[10:0];
        REG_PLANE:      cfg.plane <= cfg_data;
      endcase
    end
  end

  bsp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (start && !busy),
    .sprite_x    (sprite_x),
    .sprite_y    (sprite_y),
    .viewer_x    (viewer_x),
    .viewer_y    (viewer_y),
    .view_angle  (view_angle),
    .sprite_kind (sprite_kind),
    .out_valid   (f_valid),
    .out_side    (f_side),
    .out_num     (f_num),
    .out_den     (f_den),
    .out_cx      (f_cx)
  );

  bsp_div u_div (
    .clk        (clk),
    .rst        (rst),
    .height     (cfg.height),
    .in_valid   (f_valid),
    .in_side    (f_side),
    .in_num     (f_num),
    .in_den     (f_den),
    .in_cx      (f_cx),
    .out_valid  (d_valid),
    .out_side   (d_side),
    .out_quo    (d_quo),
    .out_rem_nz (d_rem_nz),
    .out_size   (d_size)
  );

  bsp_finish u_finish (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (d_valid),
    .in_side     (d_side),
    .in_quo      (d_quo),
    .in_rem_nz   (d_rem_nz),
    .in_size     (d_size),
    .done        (done),
    .visible     (visible),
    .col_left    (col_left),
    .col_right   (col_right),
    .row_top     (row_top),
    .row_bottom  (row_bottom),
    .center_col  (center_col),
    .sprite_size (sprite_size),
    .depth       (depth),
    .kind_out    (kind_out)
  );

endmodule

// ----- rtl/bsp_checker.sv -----
// Port-level checker for the sprite projector and its bind to the top level.
module bsp_checker import bsp_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                sprite_kind,
  input logic                done,
  input logic                visible,
  input logic [10:0]         col_left,
  input logic [10:0]         col_right,
  input logic [10:0]         row_top,
  input logic [10:0]         row_bottom,
  input logic signed [15:0]  center_col,
  input logic [15:0]         sprite_size,
  input logic [14:0]         depth,
  input logic                kind_out
);

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("request produced no result at the expected cycle");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching request");

  a_kind_kept: assert property (@(posedge clk) disable iff (rst)
    done |-> kind_out == $past(sprite_kind, LATENCY))
    else $error("sprite kind not carried to its result");

  a_cols_ordered: assert property (@(posedge clk) disable iff (rst)
    done && visible |-> col_left <= col_right)
    else $error("visible sprite with reversed column range");

  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    done && !visible |-> col_left == 11'd0 && col_right == 11'd0 && row_top == 11'd0 &&
      row_bottom == 11'd0 && center_col == 16'sd0 && sprite_size == 16'd0 &&
      depth == 15'd0)
    else $error("hidden sprite with nonzero fields");

endmodule

bind billboard_sprite_projector_core bsp_checker u_bsp_checker (.*);

// ----- tb/testbench.sv -----
// Self-checking testbench for the billboard sprite projector: directed and random requests.
module testbench;
  import bsp_pkg::*;

  localparam longint PI_V = 64'sd3373259426;
  localparam longint TWO_PI_V = 64'sd6746518852;
  localparam longint HALF_PI_V = 64'sd1686629713;
  localparam longint NEAR_V = 64'sd419430;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic        vis;
    logic [10:0] cl;
    logic [10:0] cr;
    logic [10:0] rt;
    logic [10:0] rb;
    logic [15:0] cc;
    logic [15:0] sz;
    logic [14:0] dp;
    logic        kd;
  } proj_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [13:0] sprite_x = '0, sprite_y = '0, viewer_x = '0, viewer_y = '0;
  logic [9:0] view_angle = '0;
  logic sprite_kind = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [13:0] cfg_data = '0;
  logic done, visible, kind_out;
  logic [10:0] col_left, col_right, row_top, row_bottom;
  logic signed [15:0] center_col;
  logic [15:0] sprite_size;
  logic [14:0] depth;

  logic [10:0] scr_w = 11'd640, scr_h = 11'd480, horizon = 11'd240;
  logic [13:0] plane = 14'd2365;
  proj_t expected_proj[$];
  int errors = 0;
  int cycles = 0;

  billboard_sprite_projector_core dut (.*);

  initial forever #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic longint sine_q14(longint t_in);
    longint t, sum;
    logic neg;
    longint unsigned x, x2, term;
    neg = 1'b0;
    t = t_in % TWO_PI_V;
    if (t < 0) t += TWO_PI_V;
    if (t >= PI_V) begin
      neg = 1'b1;
      t -= PI_V;
    end
    if (t > HALF_PI_V) t = PI_V - t;
    x = t;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (int k = 1; k <= 6; k++) begin
      term = (term * x2) >> 30;
      term = term / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    sum = (sum + 32768) >>> 16;
    if (sum > 16384) sum = 16384;
    return neg ? -sum : sum;
  endfunction

  function automatic proj_t project(logic [13:0] sx, sy, vx, vy, logic [9:0] ang, logic kd);
    proj_t r;
    longint dx, dy, th, s, c, cx, cy, w, h, cr, p, size, dep, dd, nn;
    longint left, right, center, top, bottom;
    r = '0;
    r.kd = kd;
    dx = longint'(sx) - longint'(vx);
    dy = longint'(sy) - longint'(vy);
    th = (TWO_PI_V * longint'(ang)) / 1024;
    s = sine_q14(th);
    c = sine_q14(th + HALF_PI_V);
    cx = dx * c + dy * s;
    cy = dy * c - dx * s;
    w = longint'(scr_w);
    h = longint'(scr_h);
    cr = longint'(horizon);
    p = (plane == 0) ? 1 : longint'(plane);
    if (cx <= NEAR_V || w == 0) return r;
    size = (h << 22) / cx;
    if (size > 65535) size = 65535;
    dep = cx >>> 14;
    if (dep > 32767) dep = 32767;
    dd = 2 * cx * p;
    nn = w * cy * 4096;
    left = ((w - size) * dd + 2 * nn) / (2 * dd);
    right = ((w + size) * dd + 2 * nn) / (2 * dd);
    center = (w * dd + 2 * nn) / (2 * dd);
    if (center > 32767) center = 32767;
    if (center < -32768) center = -32768;
    top = (2 * cr - size) / 2;
    bottom = (2 * cr + size) / 2;
    if (right < 0 || left >= w) return r;
    if (left < 0) left = 0;
    if (right > w - 1) right = w - 1;
    if (top < 0) top = 0;
    if (bottom > h - 1) bottom = h - 1;
    if (bottom < 0) bottom = 0;
    r.vis = 1'b1;
    r.cl = left[10:0];
    r.cr = right[10:0];
    r.rt = top[10:0];
    r.rb = bottom[10:0];
    r.cc = center[15:0];
    r.sz = size[15:0];
    r.dp = dep[14:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    proj_t e;
    if (!rst && done) begin
      if (expected_proj.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        e = expected_proj.pop_front();
        if (visible !== e.vis)
          report_mismatch("visible", longint'(visible), longint'(e.vis));
        if (col_left !== e.cl)
          report_mismatch("col_left", longint'(col_left), longint'(e.cl));
        if (col_right !== e.cr)
          report_mismatch("col_right", longint'(col_right), longint'(e.cr));
        if (row_top !== e.rt)
          report_mismatch("row_top", longint'(row_top), longint'(e.rt));
        if (row_bottom !== e.rb)
          report_mismatch("row_bottom", longint'(row_bottom), longint'(e.rb));
        if (center_col !== e.cc)
          report_mismatch("center_col", longint'(center_col), longint'($signed(e.cc)));
        if (sprite_size !== e.sz)
          report_mismatch("sprite_size", longint'(sprite_size), longint'(e.sz));
        if (depth !== e.dp)
          report_mismatch("depth", longint'(depth), longint'(e.dp));
        if (kind_out !== e.kd)
          report_mismatch("kind_out", longint'(kind_out), longint'(e.kd));
      end
    end
  end

  task automatic send_sprite(logic [13:0] sx, sy, vx, vy, logic [9:0] ang, logic kd,
                             int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    sprite_x <= sx;
    sprite_y <= sy;
    viewer_x <= vx;
    viewer_y <= vy;
    view_angle <= ang;
    sprite_kind <= kd;
    do @(posedge clk); while (busy);
    expected_proj.push_back(project(sx, sy, vx, vy, ang, kd));
  endtask

  task automatic drain;
    start <= 1'b0;
    while (expected_proj.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [13:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_WIDTH: scr_w = val[10:0];
      REG_HEIGHT: scr_h = val[10:0];
      REG_CENTER_ROW: horizon = val[10:0];
      default: plane = val;
    endcase
  endtask

  task automatic set_screen(logic [10:0] w, h, c, logic [13:0] p);
    drain();
    write_reg(REG_WIDTH, {3'b000, w});
    write_reg(REG_HEIGHT, {3'b000, h});
    write_reg(REG_CENTER_ROW, {3'b000, c});
    write_reg(REG_PLANE, p);
    cfg_we <= 1'b0;
  endtask

  // Sprites placed near the viewer along the heading so that most land on screen.
  task automatic send_random_sprite(int gap);
    logic [13:0] vx, vy, sx, sy;
    logic [9:0] ang;
    int span, lat, mode;
    longint s_val, c_val;
    mode = $urandom_range(0, 9);
    ang = 10'($urandom);
    if (mode < 2) begin
      send_sprite(14'($urandom), 14'($urandom), 14'($urandom), 14'($urandom), ang,
                  1'($urandom), gap);
    end else begin
      vx = 14'($urandom_range(3000, 13000));
      vy = 14'($urandom_range(3000, 13000));
      span = (mode < 4) ? $urandom_range(0, 3000) : $urandom_range(20, 1200);
      lat = int'($urandom_range(0, 2 * span)) - span;
      s_val = sine_q14((TWO_PI_V * longint'(ang)) / 1024);
      c_val = sine_q14((TWO_PI_V * longint'(ang)) / 1024 + HALF_PI_V);
      sx = 14'(longint'(vx) + (longint'(span) * c_val - longint'(lat) * s_val) / 16384);
      sy = 14'(longint'(vy) + (longint'(span) * s_val + longint'(lat) * c_val) / 16384);
      send_sprite(sx, sy, vx, vy, ang, 1'($urandom), gap);
    end
  endtask

  task automatic test_directed;
    send_sprite(14'd1000, 14'd500, 14'd500, 14'd500, 10'd0, 1'b0, 0);
    send_sprite(14'd526, 14'd500, 14'd500, 14'd500, 10'd0, 1'b1, 0);
    send_sprite(14'd525, 14'd500, 14'd500, 14'd500, 10'd0, 1'b0, 0);
    send_sprite(14'd0, 14'd500, 14'd500, 14'd500, 10'd0, 1'b1, 0);
    send_sprite(14'd16383, 14'd16383, 14'd0, 14'd0, 10'd1023, 1'b1, 0);
    send_sprite(14'd0, 14'd0, 14'd16383, 14'd16383, 10'd512, 1'b0, 0);
    send_sprite(14'd16383, 14'd0, 14'd0, 14'd16383, 10'd896, 1'b1, 1);
    send_sprite(14'd600, 14'd3000, 14'd500, 14'd500, 10'd0, 1'b0, 0);
    send_sprite(14'd600, 14'd0, 14'd500, 14'd3000, 10'd0, 1'b1, 0);
    send_sprite(14'd500, 14'd1000, 14'd500, 14'd500, 10'd256, 1'b0, 2);
    send_sprite(14'd500, 14'd0, 14'd500, 14'd500, 10'd768, 1'b1, 0);
    send_sprite(14'd8000, 14'd8000, 14'd8000, 14'd8000, 10'd300, 1'b0, 0);
    send_sprite(14'd540, 14'd505, 14'd500, 14'd500, 10'd0, 1'b1, 0);
    send_sprite(14'h2AAA, 14'h1555, 14'h1555, 14'h2AAA, 10'h155, 1'b0, 0);
    send_sprite(14'h1555, 14'h2AAA, 14'h2AAA, 14'h1555, 10'h2AA, 1'b1, 0);
  endtask

  task automatic test_random(int count, bit gaps);
    for (int i = 0; i < count; i++) send_random_sprite(gaps ? $urandom_range(0, 10) : 0);
  endtask

  task automatic test_screen_settings;
    set_screen(11'd2047, 11'd2047, 11'd0, 14'd16383);
    test_random(120, 1);
    set_screen(11'd1, 11'd1, 11'd2047, 14'd1);
    test_random(120, 1);
    set_screen(11'd0, 11'd300, 11'd150, 14'd0);
    test_random(40, 1);
    set_screen(11'd320, 11'd200, 11'd1500, 14'd4096);
    test_random(120, 0);
    set_screen(11'($urandom_range(1, 2047)), 11'($urandom_range(1, 2047)), 11'($urandom),
               14'($urandom));
    test_random(120, 1);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(300, 1);
    test_screen_settings();
    drain();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
